### sv/wrd_pkg.sv
// Shared types and constants for the weather record deframer.
// Holds record type codes, result kinds, record lengths and the result struct.
// No dependencies.
package wrd_pkg;

  // Record store geometry
  localparam int unsigned StoreDepth = 17;
  localparam int unsigned CountW     = 5;
  localparam int unsigned SumW       = 12;

  // Separator byte and record type codes
  localparam logic [7:0] SEP_BYTE   = 8'hFF;
  localparam logic [7:0] TYPE_DATE  = 8'h60;
  localparam logic [7:0] TYPE_TEMP  = 8'h42;
  localparam logic [7:0] TYPE_PRESS = 8'h46;
  localparam logic [7:0] TYPE_WIND  = 8'h48;
  localparam logic [7:0] TYPE_RAIN  = 8'h41;

  // Relative pressure offset
  localparam logic [15:0] PRESS_OFS = 16'd9;
  // Wind direction step in half degrees (22.5 deg per index)
  localparam logic [9:0]  WIND_HALF_DEG = 10'd45;

  typedef enum logic [2:0] {
    KIND_DATE  = 3'd0,
    KIND_TEMP  = 3'd1,
    KIND_PRESS = 3'd2,
    KIND_WIND  = 3'd3,
    KIND_RAIN  = 3'd4
  } kind_e;

  typedef logic [7:0] rec_byte_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  flag_bits;
    logic [3:0]  channel;
    logic [15:0] value_zero;
    logic [15:0] value_one;
    logic [15:0] value_two;
    logic [15:0] value_three;
    logic [7:0]  stamp_minute;
    logic [7:0]  stamp_hour;
    logic [7:0]  stamp_day;
    logic [7:0]  stamp_month;
    logic [7:0]  stamp_year;
  } result_t;

  // Total record length in bytes for a type byte; zero for unknown types
  function automatic logic [CountW-1:0] len_of_type(input logic [7:0] t);
    logic [CountW-1:0] len;
    len = '0;
    case (t)
      TYPE_DATE:  len = 5'd12;
      TYPE_TEMP:  len = 5'd12;
      TYPE_PRESS: len = 5'd8;
      TYPE_WIND:  len = 5'd11;
      TYPE_RAIN:  len = 5'd17;
      default:    len = '0;
    endcase
    return len;
  endfunction

endpackage

### sv/wrd_decode.sv
// Field decoder for one complete weather record.
// Turns the stored record bytes into a result struct; depends on wrd_pkg.
// Purely combinational; the caller registers the result.
module wrd_decode import wrd_pkg::*; (
  input  rec_byte_t rec_i [StoreDepth],
  output result_t   res_o
);

  logic [9:0] wind_prod;

  // Direction index times 45 half degrees
  assign wind_prod = 10'(rec_i[2][3:0]) * WIND_HALF_DEG;

  // Decode by type byte; only known types reach here
  always_comb begin
    res_o           = '0;
    res_o.flag_bits = rec_i[0];
    unique case (rec_i[1])
      TYPE_DATE: begin
        res_o.kind         = KIND_DATE;
        res_o.value_zero   = {8'h00, rec_i[9]};
        res_o.stamp_minute = rec_i[4];
        res_o.stamp_hour   = rec_i[5];
        res_o.stamp_day    = rec_i[6];
        res_o.stamp_month  = rec_i[7];
        res_o.stamp_year   = rec_i[8];
      end
      TYPE_TEMP: begin
        res_o.kind       = KIND_TEMP;
        res_o.channel    = rec_i[2][3:0];
        res_o.value_zero = {rec_i[4], rec_i[3]};
        res_o.value_one  = {8'h00, rec_i[5]};
        res_o.value_two  = {15'd0, rec_i[0][6]};
      end
      TYPE_PRESS: begin
        res_o.kind       = KIND_PRESS;
        res_o.value_zero = {4'h0, rec_i[3][3:0], rec_i[2]};
        res_o.value_one  = {4'h0, rec_i[5][3:0], rec_i[4]} + PRESS_OFS;
      end
      TYPE_WIND: begin
        res_o.kind        = KIND_WIND;
        res_o.channel     = rec_i[2][3:0];
        res_o.value_zero  = {4'h0, rec_i[6], 4'h0} + {12'd0, rec_i[5][7:4]};
        res_o.value_one   = {4'h0, rec_i[5][3:0], rec_i[4]};
        res_o.value_two   = {7'd0, wind_prod[9:1]};
        res_o.value_three = {12'd0, rec_i[0][7:4]};
      end
      default: begin
        res_o.kind         = KIND_RAIN;
        res_o.value_zero   = {rec_i[3], rec_i[2]};
        res_o.value_one    = {rec_i[5], rec_i[4]};
        res_o.value_two    = {rec_i[7], rec_i[6]};
        res_o.value_three  = {rec_i[9], rec_i[8]};
        res_o.stamp_minute = rec_i[10];
        res_o.stamp_hour   = rec_i[11];
        res_o.stamp_day    = rec_i[12];
        res_o.stamp_month  = rec_i[13];
        res_o.stamp_year   = rec_i[14];
      end
    endcase
  end

endmodule

### sv/weather_record_deframer.sv
// Top level of the weather record deframer: separator hunt, record capture,
// checksum check and result register. Depends on wrd_pkg and wrd_decode.
//
// Channel   Dir  Handshake                  Payload
// s_axis    in   s_axis_tvalid/tready       tdata[7:0] rx_byte
// m_axis    out  m_axis_tvalid/tready       tuser kind, tdata decoded fields
//
// One byte is taken per cycle while s_axis_tready is high; a decoded result
// appears in the output register the cycle after the last checksum byte is
// accepted. Input is held off only when the next byte would complete a
// record while the previous result still waits in the output register.
// Reset returns to the separator hunt with the output register empty.
module weather_record_deframer import wrd_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] rx_byte
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [2:0]   m_axis_tuser,   // [2:0] kind
  // [7:0] flag_bits, [11:8] channel, [27:12] value_zero, [43:28] value_one,
  // [59:44] value_two, [75:60] value_three, [83:76] stamp_minute,
  // [91:84] stamp_hour, [99:92] stamp_day, [107:100] stamp_month,
  // [115:108] stamp_year, [119:116] zero
  output logic [119:0] m_axis_tdata
);

  localparam logic [1:0] PH_HUNT = 2'd0;
  localparam logic [1:0] PH_SEP  = 2'd1;
  localparam logic [1:0] PH_REC  = 2'd2;

  logic [1:0]        phase_q, phase_d;
  logic [CountW-1:0] count_q, count_d;
  logic [CountW-1:0] len_q, len_d;
  logic [SumW-1:0]   sum_q, sum_d;
  rec_byte_t         store_q [StoreDepth];
  logic              out_valid_q;
  result_t           out_q;

  logic              accept;
  logic              last_byte;
  logic              store_we;
  logic [CountW-1:0] csum_idx;
  logic              csum_ok;
  logic              emit;
  result_t           dec_res;

  // Next byte closes a record: count is one below the record length
  assign last_byte = (phase_q == PH_REC) && (count_q >= 5'd2) &&
                     (count_q == len_q - 5'd1);

  // Hold the request only when a result could collide with a waiting one
  assign s_axis_tready = !out_valid_q || m_axis_tready || !last_byte;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Low checksum byte sits two below the record length
  assign csum_idx = len_q - 5'd2;
  assign csum_ok  = (s_axis_tdata[7:4] == 4'h0) &&
                    ({s_axis_tdata[3:0], store_q[csum_idx]} == sum_q);

  wrd_decode u_decode (
    .rec_i (store_q),
    .res_o (dec_res)
  );

  // Framing state machine
  always_comb begin
    phase_d  = phase_q;
    count_d  = count_q;
    len_d    = len_q;
    sum_d    = sum_q;
    store_we = 1'b0;
    emit     = 1'b0;
    if (accept) begin
      unique case (phase_q)
        PH_SEP: begin
          phase_d = (s_axis_tdata == SEP_BYTE) ? PH_REC : PH_HUNT;
          count_d = '0;
          sum_d   = '0;
        end
        PH_REC: begin
          if (count_q >= 5'(StoreDepth)) begin
            phase_d = PH_HUNT;
            count_d = '0;
            sum_d   = '0;
            len_d   = '0;
          end else if (count_q == 5'd1 && len_of_type(s_axis_tdata) == '0) begin
            // Drop unknown record type
            store_we = 1'b1;
            phase_d  = PH_HUNT;
            count_d  = '0;
            sum_d    = '0;
            len_d    = '0;
          end else begin
            store_we = 1'b1;
            if (count_q == 5'd1) begin
              len_d = len_of_type(s_axis_tdata);
            end
            if (count_q < 5'd2 || count_q < len_q - 5'd2) begin
              sum_d = sum_q + SumW'(s_axis_tdata);
            end
            count_d = count_q + 5'd1;
            if (last_byte) begin
              emit    = csum_ok;
              phase_d = PH_HUNT;
              count_d = '0;
              sum_d   = '0;
              len_d   = '0;
            end
          end
        end
        default: begin
          phase_d = (s_axis_tdata == SEP_BYTE) ? PH_SEP : PH_HUNT;
        end
      endcase
    end
  end

  // Advance control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      count_q <= '0;
      len_q   <= '0;
      sum_q   <= '0;
    end else begin
      phase_q <= phase_d;
      count_q <= count_d;
      len_q   <= len_d;
      sum_q   <= sum_d;
    end
  end

  // Capture record bytes
  always_ff @(posedge clk_i) begin
    if (store_we) begin
      store_q[count_q] <= s_axis_tdata;
    end
  end

  // Output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= dec_res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tdata  = {4'h0, out_q.stamp_year, out_q.stamp_month, out_q.stamp_day,
                          out_q.stamp_hour, out_q.stamp_minute, out_q.value_three,
                          out_q.value_two, out_q.value_one, out_q.value_zero,
                          out_q.channel, out_q.flag_bits};

endmodule
